// ===== rtl/sle_pkg.sv =====
package sle_pkg;

    localparam int RING_DEPTH_DEF = 128;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_ETB = 8'h17;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_BELL   = 3'd1;
    localparam logic [2:0] KIND_ERASE  = 3'd2;
    localparam logic [2:0] KIND_CRLF   = 3'd3;
    localparam logic [2:0] KIND_DATA   = 3'd4;
    localparam logic [2:0] KIND_EMPTY  = 3'd5;
    localparam logic [2:0] KIND_REJECT = 3'd6;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_CLR  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;
    localparam logic [1:0] CNT_LEN  = 2'd3;

    typedef struct packed {
        logic       cap;
        logic       rd_at_w;
        logic       wr_char;
        logic       wr_lf;
        logic       w_inc;
        logic       w_dec;
        logic       w_load_r;
        logic       r_inc;
        logic       pend_set;
        logic [1:0] cnt_op;
        logic       emit;
        logic [2:0] kind;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic pend;
        logic is_cr;
        logic is_bs;
        logic is_w;
        logic is_u;
        logic len_zero;
        logic full;
        logic blank;
    } t_stat;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/sle_ram.sv =====
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sle_pkg::RING_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sle_ctrl.sv =====
module sle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd  o_cmd,
    output logic          busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SCHK   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (i_stat.act) begin
                    if (!i_stat.pend) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = sle_pkg::KIND_EMPTY;
                    end else begin
                        n_state = S_RDWAIT;
                    end
                end else if (i_stat.pend) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sle_pkg::KIND_REJECT;
                end else if (i_stat.is_cr) begin
                    o_cmd.wr_lf    = 1'b1;
                    o_cmd.w_inc    = 1'b1;
                    o_cmd.pend_set = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = sle_pkg::KIND_CRLF;
                end else if (i_stat.is_bs) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.len_zero) begin
                        o_cmd.kind = sle_pkg::KIND_BELL;
                    end else begin
                        o_cmd.w_dec  = 1'b1;
                        o_cmd.cnt_op = sle_pkg::CNT_INC;
                        o_cmd.kind   = sle_pkg::KIND_ERASE;
                    end
                end else if (i_stat.is_w) begin
                    n_state = S_SCAN;
                end else if (i_stat.is_u) begin
                    o_cmd.cnt_op   = sle_pkg::CNT_LEN;
                    o_cmd.w_load_r = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = sle_pkg::KIND_ERASE;
                end else if (i_stat.full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sle_pkg::KIND_BELL;
                end else begin
                    o_cmd.wr_char = 1'b1;
                    o_cmd.w_inc   = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = sle_pkg::KIND_ECHO;
                end
            end
            S_RDWAIT: begin
                o_cmd.r_inc = 1'b1;
                o_cmd.emit  = 1'b1;
                o_cmd.kind  = sle_pkg::KIND_DATA;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.len_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sle_pkg::KIND_ERASE;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_at_w = 1'b1;
                    n_state       = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_stat.blank) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sle_pkg::KIND_ERASE;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.w_dec  = 1'b1;
                    o_cmd.cnt_op = sle_pkg::CNT_INC;
                    n_state      = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sle_dpath.sv =====
module sle_dpath #(
    parameter int RING_DEPTH = sle_pkg::RING_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_action,
    input  logic [7:0]     i_rx_char,
    input  sle_pkg::t_cmd  i_cmd,
    output sle_pkg::t_stat o_stat,
    output logic           o_done,
    output logic [2:0]     o_kind,
    output logic [7:0]     o_out_char,
    output logic [6:0]     o_erase_count,
    output logic           o_line_ready
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST     = AW'(RING_DEPTH - 1);
    localparam logic [AW-1:0] FULL_LEN = AW'(RING_DEPTH - 2);

    logic          r_act;
    logic [7:0]    r_char;
    logic [AW-1:0] r_wpos;
    logic [AW-1:0] n_wpos;
    logic [AW-1:0] r_rpos;
    logic [AW-1:0] n_rpos;
    logic          r_pend;
    logic          n_pend;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic          r_done;
    logic [2:0]    r_kind;
    logic [7:0]    r_out_char;
    logic [6:0]    r_erase_count;
    logic          r_line_ready;
    logic [7:0]    n_out_char;

    logic [AW-1:0] w_next;
    logic [AW-1:0] w_prev;
    logic [AW-1:0] r_next;
    logic [AW-1:0] len;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic          we;
    logic [7:0]    wdata;

    assign w_next = (r_wpos == LAST) ? '0 : r_wpos + AW'(1);
    assign w_prev = (r_wpos == '0) ? LAST : r_wpos - AW'(1);
    assign r_next = (r_rpos == LAST) ? '0 : r_rpos + AW'(1);
    assign len    = (r_wpos >= r_rpos) ? r_wpos - r_rpos
                                       : r_wpos - r_rpos + AW'(RING_DEPTH);

    assign raddr = i_cmd.rd_at_w ? w_prev : r_rpos;
    assign we    = i_cmd.wr_char | i_cmd.wr_lf;
    assign wdata = i_cmd.wr_lf ? sle_pkg::CH_LF : r_char;

    sle_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wpos),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_stat.act      = r_act;
    assign o_stat.pend     = r_pend;
    assign o_stat.is_cr    = (r_char == sle_pkg::CH_CR);
    assign o_stat.is_bs    = (r_char == sle_pkg::CH_BS) || (r_char == sle_pkg::CH_DEL);
    assign o_stat.is_w     = (r_char == sle_pkg::CH_ETB);
    assign o_stat.is_u     = (r_char == sle_pkg::CH_NAK);
    assign o_stat.len_zero = (len == '0);
    assign o_stat.full     = (len >= FULL_LEN);
    assign o_stat.blank    = sle_pkg::is_blank(rdata);

    always_comb begin
        n_wpos = r_wpos;
        if (i_cmd.w_inc) begin
            n_wpos = w_next;
        end else if (i_cmd.w_dec) begin
            n_wpos = w_prev;
        end else if (i_cmd.w_load_r) begin
            n_wpos = r_rpos;
        end
        n_rpos = i_cmd.r_inc ? r_next : r_rpos;
        n_pend = r_pend;
        if (i_cmd.pend_set) begin
            n_pend = 1'b1;
        end else if (i_cmd.r_inc) begin
            n_pend = (r_next != r_wpos);
        end
        case (i_cmd.cnt_op)
            sle_pkg::CNT_CLR: n_cnt = '0;
            sle_pkg::CNT_INC: n_cnt = r_cnt + AW'(1);
            sle_pkg::CNT_LEN: n_cnt = len;
            default:          n_cnt = r_cnt;
        endcase
        unique case (i_cmd.kind)
            sle_pkg::KIND_ECHO: n_out_char = r_char;
            sle_pkg::KIND_BELL: n_out_char = sle_pkg::CH_BEL;
            sle_pkg::KIND_DATA: n_out_char = rdata;
            default:            n_out_char = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_rpos <= '0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_wpos <= n_wpos;
            r_rpos <= n_rpos;
            r_pend <= n_pend;
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_act  <= i_action;
            r_char <= i_rx_char;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_cmd.emit) begin
            r_kind        <= i_cmd.kind;
            r_out_char    <= n_out_char;
            r_erase_count <= (i_cmd.kind == sle_pkg::KIND_ERASE) ? 7'(n_cnt) : 7'd0;
            r_line_ready  <= n_pend;
        end
    end

    assign o_done        = r_done;
    assign o_kind        = r_kind;
    assign o_out_char    = r_out_char;
    assign o_erase_count = r_erase_count;
    assign o_line_ready  = r_line_ready;

endmodule

// ===== rtl/serial_line_editor_unit.sv =====
// sequence: start is captured in idle, exec decides and the result is strobed from a register;
// read items add a read-wait state; word erase loops scan/check per char up to a blank
// throughput: busy falls in the cycle the result is strobed, so a new item may follow
// at once; one item is in flight at a time, the registered ring read paces the word erase
// reset: synchronous active-low, clears pointers, pending flag and controller, no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle on o_done
module serial_line_editor_unit #(
    parameter int RING_DEPTH = sle_pkg::RING_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_action,
    input  logic [7:0] i_rx_char,
    output logic       o_done,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_char,
    output logic [6:0] o_erase_count,
    output logic       o_line_ready
);

    sle_pkg::t_cmd  cmd;
    sle_pkg::t_stat stat;

    sle_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .busy   (busy)
    );

    sle_dpath #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (i_action),
        .i_rx_char    (i_rx_char),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_done       (o_done),
        .o_kind       (o_kind),
        .o_out_char   (o_out_char),
        .o_erase_count(o_erase_count),
        .o_line_ready (o_line_ready)
    );

endmodule
